@@ src/hka_pkg.sv @@
// Shared types and constants for the HID key to ASCII translator.
package hka_pkg;

	localparam int unsigned USAGE_W = 8;
	localparam int unsigned CODE_W  = 7;
	localparam int unsigned FLAGS_W = 3;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TEXT = 2'd1,
		KIND_EDIT = 2'd2
	} kind_t;

	// Modifier flag bit positions
	localparam int unsigned FLAG_SHIFT = 0;
	localparam int unsigned FLAG_CTRL  = 1;
	localparam int unsigned FLAG_CAPS  = 2;

	// Usage codes and ranges
	localparam logic [USAGE_W-1:0] USAGE_LETTER_LO = 8'h04;
	localparam logic [USAGE_W-1:0] USAGE_LETTER_HI = 8'h1d;
	localparam logic [USAGE_W-1:0] USAGE_DIGIT_LO  = 8'h1e;
	localparam logic [USAGE_W-1:0] USAGE_DIGIT_HI  = 8'h27;
	localparam logic [USAGE_W-1:0] USAGE_PUNCT_LO  = 8'h2c;
	localparam logic [USAGE_W-1:0] USAGE_PUNCT_HI  = 8'h38;
	localparam logic [USAGE_W-1:0] USAGE_CAPS      = 8'h39;
	localparam logic [USAGE_W-1:0] USAGE_ENTER     = 8'h28;
	localparam logic [USAGE_W-1:0] USAGE_ESCAPE    = 8'h29;
	localparam logic [USAGE_W-1:0] USAGE_BKSP      = 8'h2a;
	localparam logic [USAGE_W-1:0] USAGE_TAB       = 8'h2b;
	localparam logic [USAGE_W-1:0] USAGE_HOME      = 8'h4a;
	localparam logic [USAGE_W-1:0] USAGE_DELETE    = 8'h4c;
	localparam logic [USAGE_W-1:0] USAGE_END       = 8'h4d;
	localparam logic [USAGE_W-1:0] USAGE_RIGHT     = 8'h4f;
	localparam logic [USAGE_W-1:0] USAGE_LEFT      = 8'h50;
	localparam logic [USAGE_W-1:0] USAGE_DOWN      = 8'h51;
	localparam logic [USAGE_W-1:0] USAGE_UP        = 8'h52;
	localparam logic [USAGE_W-1:0] USAGE_KP_ENTER  = 8'h58;
	localparam logic [USAGE_W-1:0] USAGE_LCTRL     = 8'he0;
	localparam logic [USAGE_W-1:0] USAGE_LSHIFT    = 8'he1;
	localparam logic [USAGE_W-1:0] USAGE_RCTRL     = 8'he4;
	localparam logic [USAGE_W-1:0] USAGE_RSHIFT    = 8'he5;
	// 0xe0..0xe7 share this upper part
	localparam logic [4:0]         USAGE_MOD_HI5   = 5'b11100;

	// Dense editing key codes
	localparam logic [CODE_W-1:0] EDIT_ENTER  = 7'd0;
	localparam logic [CODE_W-1:0] EDIT_ESCAPE = 7'd1;
	localparam logic [CODE_W-1:0] EDIT_BKSP   = 7'd2;
	localparam logic [CODE_W-1:0] EDIT_TAB    = 7'd3;
	localparam logic [CODE_W-1:0] EDIT_HOME   = 7'd4;
	localparam logic [CODE_W-1:0] EDIT_DELETE = 7'd5;
	localparam logic [CODE_W-1:0] EDIT_END    = 7'd6;
	localparam logic [CODE_W-1:0] EDIT_RIGHT  = 7'd7;
	localparam logic [CODE_W-1:0] EDIT_LEFT   = 7'd8;
	localparam logic [CODE_W-1:0] EDIT_DOWN   = 7'd9;
	localparam logic [CODE_W-1:0] EDIT_UP     = 7'd10;

	localparam logic [CODE_W-1:0] ASCII_LOWER_A = 7'h61;
	localparam logic [CODE_W-1:0] ASCII_UPPER_A = 7'h41;
	localparam logic [CODE_W-1:0] ASCII_ONE     = 7'h31;
	localparam logic [CODE_W-1:0] ASCII_ZERO    = 7'h30;

endpackage

@@ src/hka_ifs.sv @@
// Valid/ready channel interfaces for key events and translated results.
interface hka_key_if;
	logic                         valid;
	logic                         ready;
	logic [hka_pkg::USAGE_W-1:0]  key_usage;
	logic                         key_pressed;

	modport source (output valid, output key_usage, output key_pressed, input ready);
	modport sink   (input valid, input key_usage, input key_pressed, output ready);
endinterface

interface hka_result_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   result_kind;
	logic [hka_pkg::CODE_W-1:0]   result_code;
	logic                         modifier_key;
	logic [hka_pkg::FLAGS_W-1:0]  modifier_snapshot;

	modport source (output valid, output result_kind, output result_code,
		output modifier_key, output modifier_snapshot, input ready);
	modport sink   (input valid, input result_kind, input result_code,
		input modifier_key, input modifier_snapshot, output ready);
endinterface

@@ src/hid_key_to_ascii.sv @@
// HID key event to ASCII / editing key translator, top level.
//
//  channel  | modport | carries
//  ---------+---------+-----------------------------------------------------
//  key      | sink    | key_usage[7:0], key_pressed
//  result   | source  | result_kind[1:0], result_code[6:0], modifier_key,
//           |         | modifier_snapshot[2:0]
//
// One result per key event, one transfer per cycle sustained while result.ready stays high.
// Path: input register s1, then result register s2, with the modifier flags
// updated as an item enters s2.
// Stalls: s1 advances whenever s2 is empty or being taken; key.ready is low
// only while s1 holds an item that cannot advance.
// Reset (arst_n low) clears both valid bits and the modifier flags.
module hid_key_to_ascii (
	input logic          clk,
	input logic          arst_n,
	hka_key_if.sink      key,
	hka_result_if.source result
);

	// Input register
	logic                        valid_s1;
	logic [hka_pkg::USAGE_W-1:0] usage_s1;
	logic                        pressed_s1;

	// Result register
	logic                        valid_s2;
	hka_pkg::kind_t              kind_s2;
	logic [hka_pkg::CODE_W-1:0]  code_s2;
	logic                        mod_s2;
	logic [hka_pkg::FLAGS_W-1:0] snap_s2;

	// Modifier flags: shift, control, caps
	logic [hka_pkg::FLAGS_W-1:0] flags_q;

	logic adv_s2;   // s1 moves into s2 this edge
	logic take_s1;  // key transfer this edge

	assign adv_s2  = valid_s1 && (!valid_s2 || result.ready);
	assign key.ready = !valid_s1 || adv_s2;
	assign take_s1 = key.valid && key.ready;

	// Translation of the s1 item
	logic [hka_pkg::FLAGS_W-1:0] flags_nxt;
	logic                        is_mod;
	hka_pkg::kind_t              kind_nxt;
	logic [hka_pkg::CODE_W-1:0]  code_nxt;
	logic [hka_pkg::CODE_W-1:0]  letter_idx;
	logic [3:0]                  digit_idx;
	logic [3:0]                  punct_idx;
	logic                        shift_f;

	function automatic logic [hka_pkg::CODE_W-1:0] punct_face(input logic [3:0] idx,
		input logic shifted);
		logic [hka_pkg::CODE_W-1:0] c;
		case (idx)
			4'd0:    c = shifted ? 7'h20 : 7'h20;  // space
			4'd1:    c = shifted ? 7'h5f : 7'h2d;
			4'd2:    c = shifted ? 7'h2b : 7'h3d;
			4'd3:    c = shifted ? 7'h7b : 7'h5b;
			4'd4:    c = shifted ? 7'h7d : 7'h5d;
			4'd5:    c = shifted ? 7'h7c : 7'h5c;
			4'd6:    c = shifted ? 7'h7c : 7'h5c;  // non-US hash acts as backslash
			4'd7:    c = shifted ? 7'h3a : 7'h3b;
			4'd8:    c = shifted ? 7'h22 : 7'h27;
			4'd9:    c = shifted ? 7'h7e : 7'h60;
			4'd10:   c = shifted ? 7'h3c : 7'h2c;
			4'd11:   c = shifted ? 7'h3e : 7'h2e;
			4'd12:   c = shifted ? 7'h3f : 7'h2f;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [hka_pkg::CODE_W-1:0] digit_shift(input logic [3:0] idx);
		logic [hka_pkg::CODE_W-1:0] c;
		case (idx)
			4'd0:    c = 7'h21;  // !
			4'd1:    c = 7'h40;  // @
			4'd2:    c = 7'h23;
			4'd3:    c = 7'h24;
			4'd4:    c = 7'h25;
			4'd5:    c = 7'h5e;
			4'd6:    c = 7'h26;
			4'd7:    c = 7'h2a;
			4'd8:    c = 7'h28;
			4'd9:    c = 7'h29;
			default: c = '0;
		endcase
		return c;
	endfunction

	always_comb begin
		is_mod = (usage_s1 == hka_pkg::USAGE_CAPS) ||
			(usage_s1[7:3] == hka_pkg::USAGE_MOD_HI5);

		// Flag update; translation sees the updated flags
		flags_nxt = flags_q;
		case (usage_s1)
			hka_pkg::USAGE_LSHIFT, hka_pkg::USAGE_RSHIFT: begin
				flags_nxt[hka_pkg::FLAG_SHIFT] = pressed_s1;
			end
			hka_pkg::USAGE_LCTRL, hka_pkg::USAGE_RCTRL: begin
				flags_nxt[hka_pkg::FLAG_CTRL] = pressed_s1;
			end
			hka_pkg::USAGE_CAPS: begin
				flags_nxt[hka_pkg::FLAG_CAPS] = flags_q[hka_pkg::FLAG_CAPS] ^ pressed_s1;
			end
			default: begin
			end
		endcase

		shift_f    = flags_nxt[hka_pkg::FLAG_SHIFT];
		letter_idx = hka_pkg::CODE_W'(usage_s1 - hka_pkg::USAGE_LETTER_LO);
		digit_idx  = 4'(usage_s1 - hka_pkg::USAGE_DIGIT_LO);
		punct_idx  = 4'(usage_s1 - hka_pkg::USAGE_PUNCT_LO);

		kind_nxt = hka_pkg::KIND_NONE;
		code_nxt = '0;
		if (pressed_s1 && !is_mod) begin
			if (usage_s1 >= hka_pkg::USAGE_LETTER_LO && usage_s1 <= hka_pkg::USAGE_LETTER_HI) begin
				kind_nxt = hka_pkg::KIND_TEXT;
				if (flags_nxt[hka_pkg::FLAG_CTRL]) begin
					code_nxt = letter_idx + 7'd1;
				end else if (shift_f ^ flags_nxt[hka_pkg::FLAG_CAPS]) begin
					code_nxt = hka_pkg::ASCII_UPPER_A + letter_idx;
				end else begin
					code_nxt = hka_pkg::ASCII_LOWER_A + letter_idx;
				end
			end else if (usage_s1 >= hka_pkg::USAGE_DIGIT_LO &&
				usage_s1 <= hka_pkg::USAGE_DIGIT_HI) begin
				kind_nxt = hka_pkg::KIND_TEXT;
				if (shift_f) begin
					code_nxt = digit_shift(digit_idx);
				end else if (digit_idx == 4'd9) begin
					code_nxt = hka_pkg::ASCII_ZERO;
				end else begin
					code_nxt = hka_pkg::ASCII_ONE + {3'd0, digit_idx};
				end
			end else if (usage_s1 >= hka_pkg::USAGE_PUNCT_LO &&
				usage_s1 <= hka_pkg::USAGE_PUNCT_HI) begin
				kind_nxt = hka_pkg::KIND_TEXT;
				code_nxt = punct_face(punct_idx, shift_f);
			end else begin
				kind_nxt = hka_pkg::KIND_EDIT;
				case (usage_s1)
					hka_pkg::USAGE_ENTER, hka_pkg::USAGE_KP_ENTER: code_nxt = hka_pkg::EDIT_ENTER;
					hka_pkg::USAGE_ESCAPE: code_nxt = hka_pkg::EDIT_ESCAPE;
					hka_pkg::USAGE_BKSP:   code_nxt = hka_pkg::EDIT_BKSP;
					hka_pkg::USAGE_TAB:    code_nxt = hka_pkg::EDIT_TAB;
					hka_pkg::USAGE_HOME:   code_nxt = hka_pkg::EDIT_HOME;
					hka_pkg::USAGE_DELETE: code_nxt = hka_pkg::EDIT_DELETE;
					hka_pkg::USAGE_END:    code_nxt = hka_pkg::EDIT_END;
					hka_pkg::USAGE_RIGHT:  code_nxt = hka_pkg::EDIT_RIGHT;
					hka_pkg::USAGE_LEFT:   code_nxt = hka_pkg::EDIT_LEFT;
					hka_pkg::USAGE_DOWN:   code_nxt = hka_pkg::EDIT_DOWN;
					hka_pkg::USAGE_UP:     code_nxt = hka_pkg::EDIT_UP;
					default: begin
						// page up/down and unknown usages
						kind_nxt = hka_pkg::KIND_NONE;
						code_nxt = '0;
					end
				endcase
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				flags_q  <= flags_nxt;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take_s1) begin
			usage_s1   <= key.key_usage;
			pressed_s1 <= key.key_pressed;
		end
		if (adv_s2) begin
			kind_s2 <= kind_nxt;
			code_s2 <= code_nxt;
			mod_s2  <= is_mod;
			snap_s2 <= flags_nxt;
		end
	end

	assign result.valid             = valid_s2;
	assign result.result_kind       = kind_s2;
	assign result.result_code       = code_s2;
	assign result.modifier_key      = mod_s2;
	assign result.modifier_snapshot = snap_s2;

`ifndef SYNTHESIS
	// Kind none always carries a zero code
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == hka_pkg::KIND_NONE |-> code_s2 == '0)
		else $error("kind none with nonzero code");

	// Modifier keys never produce a character or editing code
	a_mod_none: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && mod_s2 |-> kind_s2 == hka_pkg::KIND_NONE)
		else $error("modifier key produced a result");

	// Snapshot on display matches the live flags
	a_snap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> snap_s2 == flags_q)
		else $error("snapshot differs from modifier flags");

	// Editing codes stay in the dense range
	a_edit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == hka_pkg::KIND_EDIT |-> code_s2 <= hka_pkg::EDIT_UP)
		else $error("editing code out of range");

	// Flags change only when an item enters the result register
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(flags_q))
		else $error("modifier flags changed without a transfer");
`endif

endmodule

@@ test/hid_key_to_ascii_tb.sv @@
// Self-checking testbench for the HID key to ASCII translator: directed and random key events.
module hid_key_to_ascii_tb;
	import hka_pkg::*;

	// Idle cycles with no transfer on either channel before the run is abandoned.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Cycles to keep watching after the last result, so that a spurious result
	// arriving after it is still caught.
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned TYPING_EVENTS  = 1000;
	localparam int unsigned NOISE_EVENTS   = 300;

	// Usages that are deliberately left untranslated.
	localparam logic [USAGE_W-1:0] USAGE_NONE      = 8'h00;
	localparam logic [USAGE_W-1:0] USAGE_LALT      = 8'he2;
	localparam logic [USAGE_W-1:0] USAGE_RGUI      = 8'he7;
	localparam logic [USAGE_W-1:0] USAGE_PAGE_UP   = 8'h4b;
	localparam logic [USAGE_W-1:0] USAGE_PAGE_DOWN = 8'h4e;
	localparam logic [USAGE_W-1:0] USAGE_MAX       = 8'hff;

	// One translated key event, laid out like the result channel.
	typedef struct packed {
		kind_t               kind;
		logic [CODE_W-1:0]   code;
		logic                modifier;
		logic [FLAGS_W-1:0]  snapshot;
	} translation_t;

	logic clk;
	logic arst_n;

	hka_key_if    key_ch ();
	hka_result_if res_ch ();

	hid_key_to_ascii i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.result (res_ch)
	);

	// Shadow of the shift / control / caps flags, advanced once per key transfer.
	logic [FLAGS_W-1:0] shadow_flags = '0;
	// Translations still owed by the block, oldest first.
	translation_t       predicted_translations[$];

	int unsigned burst_left   = 0;
	int unsigned events_sent  = 0;
	int unsigned error_count  = 0;
	int unsigned idle_cycles  = 0;
	int unsigned text_seen    = 0;
	int unsigned edit_seen    = 0;
	int unsigned none_seen    = 0;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: updates the shadow flags for one event, then translates it
	// with the flags as they stand after the event.
	// ------------------------------------------------------------------
	function automatic translation_t translate_key(input logic [USAGE_W-1:0] usage,
		input logic pressed);
		translation_t      t;
		logic [CODE_W-1:0] idx;
		logic              shift;
		logic              caps;
		logic              ctrl;
		t.kind     = KIND_NONE;
		t.code     = '0;
		t.modifier = (usage == USAGE_CAPS) || (usage[7:3] == USAGE_MOD_HI5);

		// Shift and control follow the key level; caps lock toggles on press only.
		// Alt and GUI fall through and leave the flags alone.
		if (usage == USAGE_LSHIFT || usage == USAGE_RSHIFT) begin
			shadow_flags[FLAG_SHIFT] = pressed;
		end else if (usage == USAGE_LCTRL || usage == USAGE_RCTRL) begin
			shadow_flags[FLAG_CTRL] = pressed;
		end else if (usage == USAGE_CAPS && pressed) begin
			shadow_flags[FLAG_CAPS] = ~shadow_flags[FLAG_CAPS];
		end
		shift = shadow_flags[FLAG_SHIFT];
		ctrl  = shadow_flags[FLAG_CTRL];
		caps  = shadow_flags[FLAG_CAPS];

		// Releases and modifier keys never produce a character.
		if (pressed && !t.modifier) begin
			if (usage >= USAGE_LETTER_LO && usage <= USAGE_LETTER_HI) begin
				// Letters: control gives 1..26, otherwise case from shift XOR caps
				idx    = usage[CODE_W-1:0] - USAGE_LETTER_LO[CODE_W-1:0];
				t.kind = KIND_TEXT;
				if (ctrl)
					t.code = idx + 7'd1;
				else
					t.code = ((shift ^ caps) ? ASCII_UPPER_A : ASCII_LOWER_A) + idx;
			end else if (usage >= USAGE_DIGIT_LO && usage <= USAGE_DIGIT_HI) begin
				// Digit row: 1..9 then 0; shifted faces from the US layout
				idx    = usage[CODE_W-1:0] - USAGE_DIGIT_LO[CODE_W-1:0];
				t.kind = KIND_TEXT;
				if (!shift) begin
					t.code = (idx == 7'd9) ? ASCII_ZERO : ASCII_ONE + idx;
				end else begin
					case (idx)
					7'd0:    t.code = 7'h21; // !
					7'd1:    t.code = 7'h40; // @
					7'd2:    t.code = 7'h23; // #
					7'd3:    t.code = 7'h24; // $
					7'd4:    t.code = 7'h25; // %
					7'd5:    t.code = 7'h5e; // ^
					7'd6:    t.code = 7'h26; // &
					7'd7:    t.code = 7'h2a; // *
					7'd8:    t.code = 7'h28; // (
					default: t.code = 7'h29; // )
					endcase
				end
			end else if (usage >= USAGE_PUNCT_LO && usage <= USAGE_PUNCT_HI) begin
				// Space and punctuation; the non-US hash key doubles as backslash
				idx    = usage[CODE_W-1:0] - USAGE_PUNCT_LO[CODE_W-1:0];
				t.kind = KIND_TEXT;
				case (idx)
				7'd0:       t.code = 7'h20;                     // space
				7'd1:       t.code = shift ? 7'h5f : 7'h2d;     // _ -
				7'd2:       t.code = shift ? 7'h2b : 7'h3d;     // + =
				7'd3:       t.code = shift ? 7'h7b : 7'h5b;     // { [
				7'd4:       t.code = shift ? 7'h7d : 7'h5d;     // } ]
				7'd5, 7'd6: t.code = shift ? 7'h7c : 7'h5c;     // | backslash
				7'd7:       t.code = shift ? 7'h3a : 7'h3b;     // : ;
				7'd8:       t.code = shift ? 7'h22 : 7'h27;     // " '
				7'd9:       t.code = shift ? 7'h7e : 7'h60;     // ~ `
				7'd10:      t.code = shift ? 7'h3c : 7'h2c;     // < ,
				7'd11:      t.code = shift ? 7'h3e : 7'h2e;     // > .
				default:    t.code = shift ? 7'h3f : 7'h2f;     // ? /
				endcase
			end else begin
				// Editing keys, renumbered densely; page up/down and the rest drop out
				t.kind = KIND_EDIT;
				case (usage)
				USAGE_ENTER,
				USAGE_KP_ENTER: t.code = EDIT_ENTER;
				USAGE_ESCAPE:   t.code = EDIT_ESCAPE;
				USAGE_BKSP:     t.code = EDIT_BKSP;
				USAGE_TAB:      t.code = EDIT_TAB;
				USAGE_HOME:     t.code = EDIT_HOME;
				USAGE_DELETE:   t.code = EDIT_DELETE;
				USAGE_END:      t.code = EDIT_END;
				USAGE_RIGHT:    t.code = EDIT_RIGHT;
				USAGE_LEFT:     t.code = EDIT_LEFT;
				USAGE_DOWN:     t.code = EDIT_DOWN;
				USAGE_UP:       t.code = EDIT_UP;
				default:        t.kind = KIND_NONE;
				endcase
			end
		end
		t.snapshot = shadow_flags;
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Key sender. Entered and left at a falling edge. Works in bursts: valid
	// stays high from one transfer to the next inside a burst, and a random
	// gap (sometimes none) opens between bursts.
	// ------------------------------------------------------------------
	task automatic send_key_event(input logic [USAGE_W-1:0] usage, input logic pressed);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				key_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			// Mostly short bursts, now and then a long unbroken stream
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		key_ch.valid       = 1'b1;
		key_ch.key_usage   = usage;
		key_ch.key_pressed = pressed;
		do
			@(posedge clk);
		while (!key_ch.ready);
		// Transfer happened on this edge: advance the shadow state with it
		predicted_translations.push_back(translate_key(usage, pressed));
		events_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result sink: each phase picks a stall pattern at random among always
	// ready, coin toss, a fixed 2-of-5 rhythm and heavy backpressure.
	// ------------------------------------------------------------------
	initial begin : drive_ready
		int unsigned phase_cnt;
		int unsigned mode;
		phase_cnt    = 0;
		mode         = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_cnt % 48 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
			0:       res_ch.ready = 1'b1;
			1:       res_ch.ready = ($urandom_range(0, 1) == 1);
			2:       res_ch.ready = ((phase_cnt % 5) < 2);
			default: res_ch.ready = ($urandom_range(0, 7) == 0);
			endcase
			phase_cnt++;
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every result transfer is matched against the oldest
	// prediction, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		translation_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (predicted_translations.size() == 0) begin
				$error("unexpected result: kind %0d code 0x%0h modifier %0d flags %0d",
					res_ch.result_kind, res_ch.result_code, res_ch.modifier_key,
					res_ch.modifier_snapshot);
				error_count++;
			end else begin
				want = predicted_translations.pop_front();
				case (want.kind)
				KIND_TEXT: text_seen++;
				KIND_EDIT: edit_seen++;
				default:   none_seen++;
				endcase
				if (res_ch.result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, res_ch.result_kind);
					error_count++;
				end
				if (res_ch.result_code !== want.code) begin
					$error("result_code: expected 0x%0h, got 0x%0h", want.code,
						res_ch.result_code);
					error_count++;
				end
				if (res_ch.modifier_key !== want.modifier) begin
					$error("modifier_key: expected %0d, got %0d", want.modifier,
						res_ch.modifier_key);
					error_count++;
				end
				if (res_ch.modifier_snapshot !== want.snapshot) begin
					$error("modifier_snapshot: expected %0d, got %0d", want.snapshot,
						res_ch.modifier_snapshot);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a hung handshake on either side ends the run.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("[hid_key_to_ascii] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// No modifiers held: range ends of letters and digits, backslash alias,
	// and a release that must give nothing.
	task automatic test_unmodified_keys();
		send_key_event(USAGE_LETTER_LO, 1'b1);
		send_key_event(USAGE_LETTER_HI, 1'b1);
		send_key_event(USAGE_DIGIT_LO, 1'b1);
		send_key_event(USAGE_DIGIT_HI, 1'b1);
		send_key_event(USAGE_PUNCT_LO + 8'd6, 1'b1);
		send_key_event(USAGE_PUNCT_HI, 1'b0);
	endtask

	// Shift faces, shift and caps cancelling on letters, control letters,
	// caps toggling back off, and alt/GUI leaving the flags alone.
	task automatic test_modifier_keys();
		send_key_event(USAGE_LSHIFT, 1'b1);
		send_key_event(USAGE_LETTER_LO, 1'b1);
		send_key_event(USAGE_DIGIT_LO, 1'b1);
		send_key_event(USAGE_PUNCT_HI, 1'b1);
		send_key_event(USAGE_CAPS, 1'b1);
		send_key_event(USAGE_LETTER_LO, 1'b1);
		send_key_event(USAGE_LSHIFT, 1'b0);
		send_key_event(USAGE_RCTRL, 1'b1);
		send_key_event(USAGE_LETTER_HI, 1'b1);
		send_key_event(USAGE_RCTRL, 1'b0);
		send_key_event(USAGE_CAPS, 1'b1);
		send_key_event(USAGE_LALT, 1'b1);
		send_key_event(USAGE_RGUI, 1'b0);
	endtask

	// Both enter keys, the top editing code, page up/down and unknown usages.
	task automatic test_edit_and_unused();
		send_key_event(USAGE_ENTER, 1'b1);
		send_key_event(USAGE_KP_ENTER, 1'b1);
		send_key_event(USAGE_UP, 1'b1);
		send_key_event(USAGE_PAGE_UP, 1'b1);
		send_key_event(USAGE_PAGE_DOWN, 1'b1);
		send_key_event(USAGE_NONE, 1'b1);
		send_key_event(USAGE_MAX, 1'b1);
	endtask

	// Realistic typing: modifiers go down and up around press/release pairs,
	// so the key classes are met under varying flag combinations.
	task automatic test_random_typing();
		logic [USAGE_W-1:0] usage;
		int unsigned        start;
		start = events_sent;
		while (events_sent - start < TYPING_EVENTS) begin
			if ($urandom_range(0, 3) == 0)
				send_key_event(($urandom_range(0, 1) == 1) ? USAGE_LSHIFT : USAGE_RSHIFT,
					$urandom_range(0, 1) == 1);
			if ($urandom_range(0, 5) == 0)
				send_key_event(($urandom_range(0, 1) == 1) ? USAGE_LCTRL : USAGE_RCTRL,
					$urandom_range(0, 1) == 1);
			if ($urandom_range(0, 9) == 0) begin
				send_key_event(USAGE_CAPS, 1'b1);
				send_key_event(USAGE_CAPS, 1'b0);
			end
			case ($urandom_range(0, 9))
			0, 1, 2, 3: usage = USAGE_LETTER_LO + 8'($urandom_range(0, 25));
			4:          usage = USAGE_DIGIT_LO + 8'($urandom_range(0, 9));
			5:          usage = USAGE_PUNCT_LO + 8'($urandom_range(0, 12));
			6, 7: begin
				case ($urandom_range(0, 11))
				0:       usage = USAGE_ENTER;
				1:       usage = USAGE_KP_ENTER;
				2:       usage = USAGE_ESCAPE;
				3:       usage = USAGE_BKSP;
				4:       usage = USAGE_TAB;
				5:       usage = USAGE_HOME;
				6:       usage = USAGE_DELETE;
				7:       usage = USAGE_END;
				8:       usage = USAGE_RIGHT;
				9:       usage = USAGE_LEFT;
				10:      usage = USAGE_DOWN;
				default: usage = USAGE_UP;
				endcase
			end
			8:          usage = ($urandom_range(0, 1) == 1) ? USAGE_PAGE_UP : USAGE_PAGE_DOWN;
			default:    usage = 8'($urandom_range(0, 255));
			endcase
			send_key_event(usage, 1'b1);
			// Occasionally the release is lost, as with rollover
			if ($urandom_range(0, 9) != 0)
				send_key_event(usage, 1'b0);
		end
	endtask

	// Noise: any usage, any level, including stray releases and modifier bounce.
	task automatic test_random_noise();
		int unsigned n;
		for (n = 0; n < NOISE_EVENTS; n++)
			send_key_event(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		key_ch.valid       = 1'b0;
		key_ch.key_usage   = '0;
		key_ch.key_pressed = 1'b0;
		arst_n             = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unmodified_keys();
		test_modifier_keys();
		test_edit_and_unused();
		test_random_typing();
		test_random_noise();
		key_ch.valid = 1'b0;

		// Drain, then watch a little longer for stray results
		while (predicted_translations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d key events under shift/control/caps combinations and stalls",
			events_sent);
		$display("results checked: %0d text, %0d editing, %0d none", text_seen, edit_seen,
			none_seen);
		if (error_count == 0 && predicted_translations.size() == 0) begin
			$display("[hid_key_to_ascii] OK");
		end else begin
			$display("[hid_key_to_ascii] ERROR");
		end
		$finish;
	end

endmodule
